[hdl/tsasr_pkg.sv]
// Shared types and constants for the time scale ASR envelope unit.
package tsasr_pkg;

  localparam int TIME_BITS    = 24;
  localparam int SCALE_BITS   = 16;
  localparam int DELTA_BITS   = 16;
  localparam int ACTION_BITS  = 3;
  localparam int ALPHA_BITS   = 16;
  localparam int DIV_CNT_BITS = $clog2(ALPHA_BITS);
  localparam int PROD_BITS    = 2 * (SCALE_BITS + 1);

  localparam logic [SCALE_BITS-1:0] SCALE_ONE  = SCALE_BITS'(256);
  localparam logic [SCALE_BITS-1:0] SCALE_ZERO = '0;

  // Command codes on the action field; the two codes above STOP are ignored.
  localparam logic [ACTION_BITS-1:0] ACT_TICK      = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_IMMEDIATE = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_CROSSFADE = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_RESET     = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_PLAY      = 3'd4;
  localparam logic [ACTION_BITS-1:0] ACT_STOP      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_BLEND,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_TICK_ADD,
    CMD_IMMEDIATE,
    CMD_CROSSFADE,
    CMD_RESET,
    CMD_PLAY,
    CMD_STOP,
    CMD_END,
    CMD_SUSTAIN,
    CMD_DIV_ATTACK,
    CMD_DIV_RELEASE,
    CMD_DIV_STEP,
    CMD_MUL,
    CMD_BLEND,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    logic running;
    logic halted;
    logic fading;
    logic past_end;
    logic in_attack;
    logic in_release;
    logic div_last;
  } dp_status_t;

endpackage

[hdl/time_scale_asr_envelope_unit.sv]
// Sequence: every command but a live tick (running and not stopped) goes to ST_DONE, which
// loads the result once the output is free; a live tick first passes ST_EVAL, where it ends,
// sustains or is not fading, and an attack or release tick runs the radix-2 alpha divider,
// multiply and blend. Throughput: one item in flight; the next input transfer follows the
// result load, and a new item is taken while the previous result waits at the output.
// Synchronous active-high reset: idle, scale 1.0, no effect running, output empty.
module time_scale_asr_envelope_unit import tsasr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_BITS-1:0] action,
  input  logic [SCALE_BITS-1:0]  scale,
  input  logic [TIME_BITS-1:0]   duration,
  input  logic [TIME_BITS-1:0]   fade_in,
  input  logic [TIME_BITS-1:0]   fade_out,
  input  logic [DELTA_BITS-1:0]  delta,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SCALE_BITS-1:0]  world_scale,
  output logic                   active
);

  cmd_t       cmd;
  dp_status_t status;

  tsasr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tsasr_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .scale       (scale),
    .duration    (duration),
    .fade_in     (fade_in),
    .fade_out    (fade_out),
    .delta       (delta),
    .status      (status),
    .world_scale (world_scale),
    .active      (active)
  );

endmodule

[hdl/tsasr_dpath.sv]
// Datapath: effect state, serial alpha divider, blend multiplier, result register.
module tsasr_dpath import tsasr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [SCALE_BITS-1:0]  scale,
  input  logic [TIME_BITS-1:0]   duration,
  input  logic [TIME_BITS-1:0]   fade_in,
  input  logic [TIME_BITS-1:0]   fade_out,
  input  logic [DELTA_BITS-1:0]  delta,
  output dp_status_t             status,
  output logic [SCALE_BITS-1:0]  world_scale,
  output logic                   active
);

  logic [TIME_BITS-1:0]  elapsed;
  logic [TIME_BITS-1:0]  effect_length;
  logic                  running;
  logic                  fading;
  logic                  halted;
  logic [SCALE_BITS-1:0] begin_scale;
  logic [SCALE_BITS-1:0] goal_scale;
  logic [TIME_BITS-1:0]  attack_len;
  logic [TIME_BITS-1:0]  release_len;
  logic [SCALE_BITS-1:0] current_scale;

  logic [TIME_BITS:0]    rem;
  logic [TIME_BITS-1:0]  den;
  logic [ALPHA_BITS-1:0] quot;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [SCALE_BITS-1:0] blend_a;
  logic [SCALE_BITS-1:0] blend_b;
  logic signed [PROD_BITS-1:0] product;

  logic [TIME_BITS:0]    tick_sum;
  logic [TIME_BITS-1:0]  elapsed_next;
  logic [TIME_BITS:0]    rel_sum;
  logic [TIME_BITS:0]    rel_diff;
  logic [TIME_BITS:0]    rem_shift;
  logic                  rem_ge;
  logic signed [SCALE_BITS:0]   diff;
  logic signed [PROD_BITS-1:0]  product_next;
  logic signed [PROD_BITS-1:0]  rounded;

  always_comb begin
    tick_sum     = {1'b0, elapsed} + (TIME_BITS+1)'(delta);
    elapsed_next = tick_sum[TIME_BITS] ? '1 : tick_sum[TIME_BITS-1:0];
    rel_sum      = {1'b0, elapsed} + {1'b0, release_len};
    rel_diff     = rel_sum - {1'b0, effect_length};
    // rem stays below den, so the shift cannot overflow
    rem_shift    = {rem[TIME_BITS-1:0], 1'b0};
    rem_ge       = rem_shift >= {1'b0, den};
    diff         = $signed({1'b0, blend_b}) - $signed({1'b0, blend_a});
    product_next = diff * $signed({1'b0, quot});
    rounded      = product + PROD_BITS'(32768);
  end

  always_comb begin
    status.running    = running;
    status.halted     = halted;
    status.fading     = fading;
    status.past_end   = elapsed >= effect_length;
    status.in_attack  = elapsed < attack_len;
    status.in_release = rel_sum > {1'b0, effect_length};
    status.div_last   = div_cnt == DIV_CNT_BITS'(ALPHA_BITS - 1);
  end

  // Effect state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= '0;
      effect_length <= '0;
      running       <= 1'b0;
      fading        <= 1'b0;
      halted        <= 1'b0;
      begin_scale   <= SCALE_ONE;
      goal_scale    <= SCALE_ONE;
      attack_len    <= '0;
      release_len   <= '0;
      current_scale <= SCALE_ONE;
    end else begin
      unique case (cmd)
        CMD_TICK_ADD: begin
          elapsed <= elapsed_next;
        end
        CMD_IMMEDIATE: begin
          elapsed       <= '0;
          effect_length <= duration;
          running       <= 1'b1;
          fading        <= 1'b0;
          current_scale <= scale;
        end
        CMD_CROSSFADE: begin
          elapsed       <= '0;
          effect_length <= duration;
          running       <= 1'b1;
          fading        <= 1'b1;
          goal_scale    <= scale;
          attack_len    <= fade_in;
          release_len   <= fade_out;
          begin_scale   <= current_scale;
          if (fade_in == '0) begin
            current_scale <= scale;
          end
        end
        CMD_RESET, CMD_END: begin
          current_scale <= SCALE_ONE;
          running       <= 1'b0;
          fading        <= 1'b0;
        end
        CMD_PLAY: begin
          current_scale <= SCALE_ONE;
          halted        <= 1'b0;
          fading        <= 1'b0;
        end
        CMD_STOP: begin
          current_scale <= SCALE_ZERO;
          halted        <= 1'b1;
        end
        CMD_SUSTAIN: begin
          current_scale <= goal_scale;
        end
        CMD_BLEND: begin
          // a + round((b - a) * alpha / 2^16), result lies between a and b
          current_scale <= blend_a + rounded[SCALE_BITS+ALPHA_BITS-1:ALPHA_BITS];
        end
        default: begin
        end
      endcase
    end
  end

  // Divider, multiplier and result register
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_DIV_ATTACK: begin
        rem     <= {1'b0, elapsed};
        den     <= attack_len;
        quot    <= '0;
        div_cnt <= '0;
        blend_a <= begin_scale;
        blend_b <= goal_scale;
      end
      CMD_DIV_RELEASE: begin
        rem     <= {1'b0, rel_diff[TIME_BITS-1:0]};
        den     <= release_len;
        quot    <= '0;
        div_cnt <= '0;
        blend_a <= goal_scale;
        blend_b <= SCALE_ONE;
      end
      CMD_DIV_STEP: begin
        rem     <= rem_ge ? rem_shift - {1'b0, den} : rem_shift;
        quot    <= {quot[ALPHA_BITS-2:0], rem_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      CMD_MUL: begin
        product <= product_next;
      end
      CMD_LOAD_OUT: begin
        world_scale <= current_scale;
        active      <= running && !halted;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/tsasr_ctrl.sv]
// Controller: command sequencing and output handshake.
module tsasr_ctrl import tsasr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_BITS-1:0] action,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  dp_status_t             status,
  output cmd_t                   cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   tick_live;

  assign out_free  = !out_valid || out_ready;
  assign tick_live = status.running && !status.halted;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_LOAD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (action == ACT_TICK && tick_live) ? ST_EVAL : ST_DONE;
        end
      end
      ST_EVAL: begin
        if (!status.past_end && status.fading &&
            (status.in_attack || status.in_release)) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_BLEND;
      ST_BLEND: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NOP;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (action)
            ACT_TICK:      cmd = tick_live ? CMD_TICK_ADD : CMD_NOP;
            ACT_IMMEDIATE: cmd = CMD_IMMEDIATE;
            ACT_CROSSFADE: cmd = CMD_CROSSFADE;
            ACT_RESET:     cmd = CMD_RESET;
            ACT_PLAY:      cmd = CMD_PLAY;
            ACT_STOP:      cmd = CMD_STOP;
            default:       cmd = CMD_NOP;
          endcase
        end
      end
      ST_EVAL: begin
        priority if (status.past_end) begin
          cmd = CMD_END;
        end else if (!status.fading) begin
          cmd = CMD_NOP;
        end else if (status.in_attack) begin
          cmd = CMD_DIV_ATTACK;
        end else if (status.in_release) begin
          cmd = CMD_DIV_RELEASE;
        end else begin
          cmd = CMD_SUSTAIN;
        end
      end
      ST_DIV:   cmd = CMD_DIV_STEP;
      ST_MUL:   cmd = CMD_MUL;
      ST_BLEND: cmd = CMD_BLEND;
      ST_DONE: begin
        if (out_free) begin
          cmd = CMD_LOAD_OUT;
        end
      end
      default: cmd = CMD_NOP;
    endcase
  end

endmodule

[hdl/tsasr_checker.sv]
// Port-level checks for the time scale ASR envelope unit, bound to the top level.
module tsasr_checker import tsasr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SCALE_BITS-1:0] world_scale,
  input logic                  active
);

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(world_scale) && $stable(active))
    else $error("result changed while stalled");

  // One item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // Reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // A result only appears after the block was busy with an item
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item in work");

endmodule

bind time_scale_asr_envelope_unit tsasr_checker u_tsasr_checker (.*);
